[hdl/vtmc_pkg.sv]
// Shared types, constants and helpers for the vertex/track multi-cut counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vtmc_pkg;

    localparam int NUM_SEL   = 6;   // selection cells in the chain (1..6)
    localparam int CNT_W     = 16;  // internal saturating counter width (8..32)
    localparam int OUT_W     = 16;  // reported count width
    localparam int SEL_IDX_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int SEL_W     = 64;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;

    // selection word layout
    localparam int PT_LO = 0;
    localparam int PT_HI = 23;
    localparam int Z0_LO = 24;
    localparam int Z0_HI = 43;
    localparam int DZ_LO = 44;
    localparam int DZ_HI = 63;

    // result word layout
    localparam int M_IDX_LO   = 0;
    localparam int M_CNT_LO   = 3;
    localparam int M_TOT_LO   = 19;
    localparam int M_VZ_LO    = 35;
    localparam int M_FOUND_B  = 51;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_USE = 3'd6;

    typedef enum logic [1:0] {
        REQ_VERTEX = 2'd0,
        REQ_TRACK  = 2'd1,
        REQ_END    = 2'd2
    } req_t;

    typedef logic [NUM_SEL*OUT_W-1:0] cnt_vec_t;

    // token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               is_end;
        logic [23:0]        pt;
        logic [15:0]        az0;
        logic [16:0]        proj;
        logic [OUT_W-1:0]   total;
        logic signed [15:0] vz;
        logic               found;
        cnt_vec_t           counts;
    } tok_t;

    function automatic logic [OUT_W-1:0] cap_out(input logic [CNT_W-1:0] c);
        return (|(c >> OUT_W)) ? '1 : OUT_W'(c);
    endfunction

endpackage

[hdl/vtmc_front.sv]
// Front end: best-vertex tracking, track total, |z0|, |z0 - vz| and the
// projected dz multiply. Two register stages. Depends on vtmc_pkg.
`timescale 1ns / 1ps

module vtmc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 acc,
    input  logic [1:0]           req,
    input  logic [15:0]          weight,
    input  logic signed [15:0]   vtx_z,
    input  logic [23:0]          pt,
    input  logic signed [15:0]   z0,
    input  logic [15:0]          sin_theta,
    output vtmc_pkg::tok_t       tok_o
);
    import vtmc_pkg::*;

    logic [15:0]        best_w_reg, best_w_next;
    logic               have_reg, have_next;
    logic signed [15:0] chosen_z_reg, chosen_z_next;
    logic [CNT_W-1:0]   total_reg, total_next;

    // stage A
    logic               a_valid_reg, a_valid_next;
    logic               a_end_reg;
    logic [23:0]        a_pt_reg;
    logic [15:0]        a_az0_reg, a_ad_reg, a_sin_reg;
    logic [OUT_W-1:0]   a_total_reg;
    logic signed [15:0] a_vz_reg;
    logic               a_found_reg;

    // stage B
    tok_t tok_reg, tok_next;

    logic [16:0] diff, diff_neg, z0_ext, z0_neg;
    logic [15:0] ad, az0;
    logic [31:0] prod;

    always_comb begin
        z0_ext   = {z0[15], z0};
        z0_neg   = 17'd0 - z0_ext;
        az0      = z0[15] ? z0_neg[15:0] : z0_ext[15:0];
        diff     = z0_ext - {chosen_z_reg[15], chosen_z_reg};
        diff_neg = 17'd0 - diff;
        ad       = diff[16] ? diff_neg[15:0] : diff[15:0];
    end

    always_comb begin
        best_w_next   = best_w_reg;
        have_next     = have_reg;
        chosen_z_next = chosen_z_reg;
        total_next    = total_reg;
        a_valid_next  = 1'b0;
        if (acc) begin
            case (req)
                REQ_VERTEX: begin
                    if (!have_reg || weight > best_w_reg) begin
                        best_w_next   = weight;
                        chosen_z_next = vtx_z;
                        have_next     = 1'b1;
                    end
                end
                REQ_TRACK: begin
                    a_valid_next = 1'b1;
                    if (total_reg != '1) begin
                        total_next = total_reg + 1'b1;
                    end
                end
                REQ_END: begin
                    a_valid_next  = 1'b1;
                    best_w_next   = '0;
                    have_next     = 1'b0;
                    chosen_z_next = '0;
                    total_next    = '0;
                end
                default: a_valid_next = 1'b0;
            endcase
        end
    end

    // stage B: projected dz = |z0 - vz| * sin >> 15
    always_comb begin
        prod            = a_ad_reg * a_sin_reg;
        tok_next.valid  = a_valid_reg;
        tok_next.is_end = a_end_reg;
        tok_next.pt     = a_pt_reg;
        tok_next.az0    = a_az0_reg;
        tok_next.proj   = prod[31:15];
        tok_next.total  = a_total_reg;
        tok_next.vz     = a_vz_reg;
        tok_next.found  = a_found_reg;
        tok_next.counts = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_w_reg   <= '0;
            have_reg     <= 1'b0;
            chosen_z_reg <= '0;
            total_reg    <= '0;
            a_valid_reg  <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            best_w_reg   <= best_w_next;
            have_reg     <= have_next;
            chosen_z_reg <= chosen_z_next;
            total_reg    <= total_next;
            a_valid_reg  <= a_valid_next;
            a_end_reg    <= (req == REQ_END);
            a_pt_reg     <= pt;
            a_az0_reg    <= az0;
            a_ad_reg     <= ad;
            a_sin_reg    <= sin_theta;
            a_total_reg  <= cap_out(total_reg);
            a_vz_reg     <= chosen_z_reg;
            a_found_reg  <= have_reg;
            tok_reg      <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

[hdl/vtmc_cell.sv]
// One selection cell: applies its three cuts to each passing track and holds
// that selection's saturating count. Depends on vtmc_pkg.
`timescale 1ns / 1ps

module vtmc_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        en,
    input  logic [vtmc_pkg::SEL_W-1:0]  sel_word,
    input  vtmc_pkg::tok_t              tok_i,
    output vtmc_pkg::tok_t              tok_o
);
    import vtmc_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    tok_t             tok_reg, tok_next;
    logic             pass;

    assign pass = (tok_i.pt >= sel_word[PT_HI:PT_LO])
               && ({4'b0, tok_i.az0} < sel_word[Z0_HI:Z0_LO])
               && ({3'b0, tok_i.proj} < sel_word[DZ_HI:DZ_LO]);

    always_comb begin
        cnt_next = cnt_reg;
        tok_next = tok_i;
        if (tok_i.valid) begin
            if (tok_i.is_end) begin
                // shift own count into the word; cell 0 ends in the top slot
                tok_next.counts = (tok_i.counts << OUT_W) | cnt_vec_t'(cap_out(cnt_reg));
                cnt_next        = '0;
            end else if (en && pass && cnt_reg != '1) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            cnt_reg <= cnt_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

[hdl/vertex_track_multi_cut_counter_core.sv]
// Top level of the vertex/track multi-cut counter: config registers, front
// end, chain of selection cells and result unloader. Depends on vtmc_pkg.
`timescale 1ns / 1ps

// Takes one word per cycle on the s_ side: vertices, then tracks, then one
// end-of-event word. The front end keeps the z of the heaviest vertex (first
// wins ties, 0 when none) and forms |z0| and the projected dz over two
// register stages (one 16x16 multiply); the word then walks a chain of
// NUM_SEL cells, one cell per cycle unless the chain holds, each cell
// applying its selection's cuts and bumping its own saturating counter.
// When the end word leaves the last cell it carries every count, and the
// unloader sends one result per selection in use, index 0 first, tlast on
// the last. Input throughput is one word per cycle; the input stalls only
// when an end word reaches the unloader while the previous event's results
// are still being drained. Config writes are always taken (cfg_ready is
// tied high).

module vertex_track_multi_cut_counter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: vertex_weight[15:0], vertex_z[31:16], track_pt[55:32],
    //        track_z0[71:56], track_sin_theta[87:72]
    input  logic [vtmc_pkg::S_TDATA_W-1:0]      s_tdata,
    // tuser: req_type[1:0]
    input  logic [vtmc_pkg::S_TUSER_W-1:0]      s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: selection_index[2:0], selection_count[18:3], total_tracks[34:19],
    //        best_vertex_z[50:35], vertex_found[51], zero[55:52]
    output logic [vtmc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,   // last_result
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vtmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vtmc_pkg::SEL_W-1:0]          cfg_data
);
    import vtmc_pkg::*;

    // config
    logic [SEL_W-1:0]     sel_word_reg [NUM_SEL];
    logic [2:0]           in_use_reg;
    logic [SEL_IDX_W-1:0] n_eff;

    // pipeline
    logic adv, acc;
    tok_t tok_w [NUM_SEL+1];
    tok_t tail;

    // unloader
    logic                 busy_reg;
    logic [SEL_IDX_W-1:0] idx_reg, n_reg;
    cnt_vec_t             cnts_reg;
    logic [OUT_W-1:0]     total_reg;
    logic signed [15:0]   vz_reg;
    logic                 found_reg;
    logic                 last, free, load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SEL; i++) begin
                sel_word_reg[i] <= '0;
            end
            in_use_reg <= 3'd1;
        end else if (cfg_valid) begin
            for (int i = 0; i < NUM_SEL; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    sel_word_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == CFG_IN_USE) begin
                in_use_reg <= cfg_data[2:0];
            end
        end
    end

    // 0 counts as 1, anything above the cell count as the cell count
    always_comb begin
        if (in_use_reg == 3'd0) begin
            n_eff = SEL_IDX_W'(1);
        end else if (in_use_reg > SEL_IDX_W'(NUM_SEL)) begin
            n_eff = SEL_IDX_W'(NUM_SEL);
        end else begin
            n_eff = in_use_reg;
        end
    end

    // the whole chain moves together; it holds only when an end word
    // would enter a busy unloader
    assign tail     = tok_w[NUM_SEL];
    assign last     = (idx_reg == n_reg - 1'b1);
    assign free     = !busy_reg || (m_tready && last);
    assign adv      = !(tail.valid && tail.is_end) || free;
    assign load     = tail.valid && tail.is_end && free;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;

    vtmc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .acc       (acc),
        .req       (s_tuser[1:0]),
        .weight    (s_tdata[15:0]),
        .vtx_z     (s_tdata[31:16]),
        .pt        (s_tdata[55:32]),
        .z0        (s_tdata[71:56]),
        .sin_theta (s_tdata[87:72]),
        .tok_o     (tok_w[0])
    );

    for (genvar gi = 0; gi < NUM_SEL; gi++) begin : g_cell
        vtmc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .en       (SEL_IDX_W'(gi) < n_eff),
            .sel_word (sel_word_reg[gi]),
            .tok_i    (tok_w[gi]),
            .tok_o    (tok_w[gi+1])
        );
    end

    // unloader: counts arrive with cell 0 in the top slot, shift out from the top
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            n_reg    <= SEL_IDX_W'(1);
        end else if (load) begin
            busy_reg  <= 1'b1;
            idx_reg   <= '0;
            n_reg     <= n_eff;
            cnts_reg  <= tail.counts;
            total_reg <= tail.total;
            vz_reg    <= tail.vz;
            found_reg <= tail.found;
        end else if (busy_reg && m_tready) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
            cnts_reg <= cnts_reg << OUT_W;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tdata  = {4'b0, found_reg, vz_reg, total_reg,
                       cnts_reg[NUM_SEL*OUT_W-1 -: OUT_W], idx_reg};

endmodule

[hdl/vtmc_checker.sv]
// Port-level checker for the vertex/track multi-cut counter, bound to the
// top level. Depends on vtmc_pkg.
`timescale 1ns / 1ps

module vtmc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vtmc_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);
    import vtmc_pkg::*;

    logic m_hs;
    assign m_hs = m_tvalid && m_tready;

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // results of one event count up from the previous index
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_hs && !m_tlast |=> !m_tvalid
            || m_tdata[M_IDX_LO +: 3] == $past(m_tdata[M_IDX_LO +: 3]) + 3'd1)
        else $error("selection index out of sequence");

    // total and vertex fields are shared by all results of an event
    a_event_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_hs && !m_tlast |=> !m_tvalid
            || m_tdata[M_FOUND_B:M_TOT_LO] == $past(m_tdata[M_FOUND_B:M_TOT_LO]))
        else $error("event fields differ within one event");

    // no vertex means z of zero
    a_no_vtx_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_FOUND_B] |-> m_tdata[M_VZ_LO +: 16] == 16'd0)
        else $error("vertex z nonzero without a vertex");

    // index never exceeds the cell count
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_IDX_LO +: 3] < 3'(NUM_SEL))
        else $error("selection index beyond cell count");

endmodule

bind vertex_track_multi_cut_counter_core vtmc_checker u_vtmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
